/* src/box_sum_3x3_window_assert.svh */
// Assertion macros shared by the checker.
`ifndef BOX_SUM_3X3_WINDOW_ASSERT_SVH
`define BOX_SUM_3X3_WINDOW_ASSERT_SVH

// Same-cycle implication, gated off while reset is active.
`define BSW_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("box_sum_3x3_window check failed");

// Next-cycle implication, gated off while reset is active.
`define BSW_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("box_sum_3x3_window check failed");

`endif

/* src/bsw_pkg.sv */
`timescale 1ns / 1ps

package bsw_pkg;

  localparam int unsigned PIX_W        = 8;
  localparam int unsigned COL_SUM_W    = 10;
  localparam int unsigned SUM_W        = 12;
  localparam int unsigned CFG_W        = 11;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned DEF_MAX_COLS = 1024;
  localparam int unsigned DEF_MAX_ROWS = 1024;
  localparam logic [SUM_W-1:0] SUM_MAX = 12'd2295;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ACTIVE_COLS,
    REG_ACTIVE_ROWS
  } cfg_reg_e;

  // One window column, oldest row on top.
  typedef struct packed {
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] bot;
  } win_col_t;

endpackage

/* src/bsw_ram.sv */
`timescale 1ns / 1ps

module bsw_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/bsw_cell.sv */
`timescale 1ns / 1ps

// One window column; shifts its content to the next cell on each step.
module bsw_cell (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               shift_i,
  input  bsw_pkg::win_col_t                  col_i,
  output bsw_pkg::win_col_t                  col_o,
  output logic [bsw_pkg::COL_SUM_W-1:0]      col_sum_o
);
  import bsw_pkg::*;

  win_col_t col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
    end else if (shift_i) begin
      col_q <= col_i;
    end
  end

  // Sum of the column this cell holds after the shift.
  assign col_sum_o = COL_SUM_W'(col_i.top) + COL_SUM_W'(col_i.mid) + COL_SUM_W'(col_i.bot);
  assign col_o     = col_q;

endmodule

/* src/box_sum_3x3_window.sv */
`timescale 1ns / 1ps
// A result item passes the stage 1 and output registers after the edge that accepts the
// pixel item completing its window. Throughput: 1 pixel item per cycle unless results
// stall; one line-RAM read and one write per cycle set it.
// Border pixels give no result item; only interior positions (row >= 2, col >= 2) do.
// Reset: counters, window cells and pipeline valids clear; active_cols/rows go to the maximum.
// The line RAM is not cleared; stale entries read in an image's first two rows give no result.
module box_sum_3x3_window #(
  parameter int unsigned MAX_COLS = bsw_pkg::DEF_MAX_COLS,
  parameter int unsigned MAX_ROWS = bsw_pkg::DEF_MAX_ROWS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration
  input  logic                           cfg_we_i,
  input  logic [bsw_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bsw_pkg::CFG_W-1:0]      cfg_wdata_i,
  // pixel items in
  input  logic                           pixel_valid_i,
  output logic                           pixel_ready_o,
  input  logic [bsw_pkg::PIX_W-1:0]      pixel_i,
  // result items out
  output logic                           result_valid_o,
  input  logic                           result_ready_i,
  output logic [bsw_pkg::SUM_W-1:0]      window_sum_o,
  output logic                           row_end_o,
  output logic                           frame_end_o
);
  import bsw_pkg::*;

  localparam int unsigned CW  = $clog2(MAX_COLS);
  localparam int unsigned RW  = $clog2(MAX_ROWS);
  localparam int unsigned MW  = (CW > RW) ? CW : RW;
  // wide enough for a raw register value and for MAX_COLS / MAX_ROWS themselves
  localparam int unsigned LW  = (CFG_W > MW + 1) ? CFG_W : MW + 1;
  localparam int unsigned LNW = 2 * PIX_W;

  // Saturate a dimension to 3..hi and return it minus one (last index).
  function automatic logic [LW-1:0] last_of(input logic [LW-1:0] v, input logic [LW-1:0] hi);
    logic [LW-1:0] r;
    if (v < LW'(3)) begin
      r = LW'(2);
    end else if (v > hi) begin
      r = hi - LW'(1);
    end else begin
      r = v - LW'(1);
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration: keep the saturated last column / last row index.
  // ---------------------------------------------------------------------------
  logic [CW-1:0] last_col_q;
  logic [RW-1:0] last_row_q;
  logic [LW-1:0] cfg_last_cols;
  logic [LW-1:0] cfg_last_rows;

  assign cfg_last_cols = last_of(LW'(cfg_wdata_i), LW'(MAX_COLS));
  assign cfg_last_rows = last_of(LW'(cfg_wdata_i), LW'(MAX_ROWS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_col_q <= CW'(MAX_COLS - 1);
      last_row_q <= RW'(MAX_ROWS - 1);
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_ACTIVE_COLS: last_col_q <= cfg_last_cols[CW-1:0];
        REG_ACTIVE_ROWS: last_row_q <= cfg_last_rows[RW-1:0];
        default: ;  // unknown index: ignored
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake. Stage 1 waits on the line-RAM read; the output register
  // decouples it from the consumer.
  // ---------------------------------------------------------------------------
  logic s1_valid_q;
  logic s1_fire;
  logic in_fire;
  logic out_valid_q;

  assign s1_fire       = s1_valid_q && (!out_valid_q || result_ready_i);
  assign pixel_ready_o = !s1_valid_q || s1_fire;
  assign in_fire       = pixel_valid_i && pixel_ready_o;

  // ---------------------------------------------------------------------------
  // Stage 0: raster position of the incoming pixel.
  // ---------------------------------------------------------------------------
  logic [CW-1:0] col_q;
  logic [RW-1:0] row_q;
  logic          at_last_col;
  logic          at_last_row;

  assign at_last_col = (col_q >= last_col_q);
  assign at_last_row = (row_q >= last_row_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_fire) begin
      if (at_last_col) begin
        col_q <= '0;
        row_q <= at_last_row ? '0 : row_q + RW'(1);
      end else begin
        col_q <= col_q + CW'(1);
      end
    end
  end

  // Stage 1 item: pixel, its column and the result flags.
  logic [PIX_W-1:0] s1_pix_q;
  logic [CW-1:0]    s1_col_q;
  logic             s1_emit_q;
  logic             s1_row_end_q;
  logic             s1_frame_end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_pix_q       <= pixel_i;
      s1_col_q       <= col_q;
      s1_emit_q      <= (row_q >= RW'(2)) && (col_q >= CW'(2));
      s1_row_end_q   <= at_last_col;
      s1_frame_end_q <= at_last_col && at_last_row;
    end
  end

  // ---------------------------------------------------------------------------
  // Line buffers: one word per column, {row-2, row-1}. Read on accept, written
  // back shifted up by one row when stage 1 moves on. The write and the next
  // read always hit different columns since a row has at least 3 columns.
  // ---------------------------------------------------------------------------
  logic [LNW-1:0]   line_rdata;
  logic [PIX_W-1:0] up2;
  logic [PIX_W-1:0] up1;

  bsw_ram #(
    .WIDTH (LNW),
    .DEPTH (MAX_COLS)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (s1_fire),
    .waddr_i (s1_col_q),
    .wdata_i ({up1, s1_pix_q}),
    .re_i    (in_fire),
    .raddr_i (col_q),
    .rdata_o (line_rdata)
  );

  assign up2 = line_rdata[LNW-1:PIX_W];
  assign up1 = line_rdata[PIX_W-1:0];

  // ---------------------------------------------------------------------------
  // Window: three column cells in a chain, newest column enters cell 0.
  // Each cell reports the sum of the column it holds after the shift.
  // ---------------------------------------------------------------------------
  win_col_t               new_col;
  win_col_t               col0;
  win_col_t               col1;
  logic [COL_SUM_W-1:0]   csum0;
  logic [COL_SUM_W-1:0]   csum1;
  logic [COL_SUM_W-1:0]   csum2;

  assign new_col = '{top: up2, mid: up1, bot: s1_pix_q};

  bsw_cell u_cell0 (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .shift_i   (s1_fire),
    .col_i     (new_col),
    .col_o     (col0),
    .col_sum_o (csum0)
  );

  bsw_cell u_cell1 (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .shift_i   (s1_fire),
    .col_i     (col0),
    .col_o     (col1),
    .col_sum_o (csum1)
  );

  // oldest column; nothing downstream of it
  bsw_cell u_cell2 (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .shift_i   (s1_fire),
    .col_i     (col1),
    .col_o     (),
    .col_sum_o (csum2)
  );

  // ---------------------------------------------------------------------------
  // Output register.
  // ---------------------------------------------------------------------------
  logic [SUM_W-1:0] sum_d;
  logic [SUM_W-1:0] sum_q;
  logic             row_end_q;
  logic             frame_end_q;

  assign sum_d = SUM_W'(csum0) + SUM_W'(csum1) + SUM_W'(csum2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire && s1_emit_q) begin
      out_valid_q <= 1'b1;
    end else if (result_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_emit_q) begin
      sum_q       <= sum_d;
      row_end_q   <= s1_row_end_q;
      frame_end_q <= s1_frame_end_q;
    end
  end

  assign result_valid_o = out_valid_q;
  assign window_sum_o   = sum_q;
  assign row_end_o      = row_end_q;
  assign frame_end_o    = frame_end_q;

endmodule

/* src/bsw_checker.sv */
`timescale 1ns / 1ps
`include "box_sum_3x3_window_assert.svh"

module bsw_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       pixel_valid_i,
  input logic                       pixel_ready_o,
  input logic                       result_valid_o,
  input logic                       result_ready_i,
  input logic [bsw_pkg::SUM_W-1:0]  window_sum_o,
  input logic                       row_end_o,
  input logic                       frame_end_o
);
  import bsw_pkg::*;

  // nine 8-bit pixels never sum past the full-white value
  `BSW_ASSERT_IMPL(a_sum_range, result_valid_o, window_sum_o <= SUM_MAX)

  // the last result of an image is also the last of its row
  `BSW_ASSERT_IMPL(a_frame_in_row, result_valid_o && frame_end_o, row_end_o)

  // a stalled result item holds
  `BSW_ASSERT_NEXT(a_hold, result_valid_o && !result_ready_i,
                   result_valid_o && $stable(window_sum_o) && $stable(row_end_o)
                   && $stable(frame_end_o))

  // a rising result valid requires an earlier accepted pixel item
  `BSW_ASSERT_IMPL(a_latency, $rose(result_valid_o), $past(pixel_valid_i && pixel_ready_o, 2))

endmodule

bind box_sum_3x3_window bsw_checker u_bsw_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .pixel_valid_i  (pixel_valid_i),
  .pixel_ready_o  (pixel_ready_o),
  .result_valid_o (result_valid_o),
  .result_ready_i (result_ready_i),
  .window_sum_o   (window_sum_o),
  .row_end_o      (row_end_o),
  .frame_end_o    (frame_end_o)
);
